FILE: rtl/stt_pkg.sv
// Shared types and codes for the software timer table.
// No dependencies; imported by stt_cell and software_timer_table.
`default_nettype none
package stt_pkg;
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NO_TIMER      = 3'd1;
  localparam logic [2:0] ST_WRONG_TYPE    = 3'd2;
  localparam logic [2:0] ST_FULL          = 3'd3;
  localparam logic [2:0] ST_ZERO_INTERVAL = 3'd4;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // One timer slot as it travels around the ring
  typedef struct packed {
    logic [31:0] id;          // zero means free
    logic        is_interval;
    logic [31:0] interval;
    logic [31:0] countdown;
  } slot_rec_t;
endpackage
`default_nettype wire

FILE: rtl/stt_cell.sv
// One ring cell of the timer table: holds one slot record.
// Depends on stt_pkg.
`default_nettype none
module stt_cell import stt_pkg::*; (
  input  wire            clk,
  input  wire            rst,
  input  wire            shift,
  input  wire slot_rec_t rec_in,
  output slot_rec_t      rec_out
);
  slot_rec_t rec;

  // id clears on reset so every slot starts free; the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      rec.id <= '0;
    end else if (shift) begin
      rec <= rec_in;
    end
  end

  assign rec_out = rec;
endmodule
`default_nettype wire

FILE: rtl/software_timer_table.sv
// Software timer table top level: control sequencer around a ring of slot cells.
// Depends on stt_pkg and stt_cell.
//
// Usage: one input channel (in_valid/in_ready) carries commands: set, clear,
// reset and tick. One output channel (out_valid/out_ready) returns result words.
// Set, clear and reset return one word. A tick returns one word per expired
// timer in slot order, then a final word with the next deadline; last marks
// the final word of every command.
// The slots sit in a ring of SLOTS cells that rotates by one per cycle while a
// command runs; the sequencer handles the record at the head, so each command
// takes one full turn of the ring before its final word. A set of an interval
// timer with zero duration answers without turning the ring. One command is in
// flight at a time.
// When the receiver stalls, the ring holds wherever a fire word cannot leave
// the output register, and resumes once it is taken.
// Reset frees every slot and clears salt and last deadline; it is usable
// on the next cycle.
`default_nettype none
module software_timer_table import stt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  kind,
  input  wire         is_interval,
  input  wire  [31:0] timer_id,
  input  wire  [31:0] duration_ms,
  input  wire  [31:0] elapsed_ms,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  status,
  output logic [31:0] issued_id,
  output logic        fired,
  output logic [5:0]  fired_slot,
  output logic [31:0] next_deadline,
  output logic        last
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic [IW-1:0] idx;

  // latched command
  logic [1:0]  c_kind;
  logic        c_int;
  logic [31:0] c_tid;
  logic [31:0] c_dur;
  logic [31:0] c_el;

  logic [2:0]  res_status;
  logic [31:0] res_id;
  logic        found;
  logic [23:0] salt;
  logic [31:0] last_deadline;
  logic [31:0] mind;

  slot_rec_t chain [SLOTS+1];
  slot_rec_t head, upd;
  logic      shift, fire, out_free, out_load;

  assign idx      = cnt[IW-1:0];
  assign head     = chain[0];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // ring of cells; the tail takes the processed head record
  assign chain[SLOTS] = upd;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    stt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .rec_in  (chain[g+1]),
      .rec_out (chain[g])
    );
  end

  // head processing
  logic        live, match, due;
  logic [23:0] salt1;
  logic [31:0] new_id, delta;
  always_comb begin
    upd    = head;
    fire   = 1'b0;
    live   = (head.id != '0);
    match  = live && (c_tid[31:24] == 8'(idx)) && (head.id == c_tid);
    due    = head.countdown <= c_el;
    salt1  = salt + 24'd1;
    if (idx == '0 && salt1 == '0) begin
      salt1 = 24'd1;
    end
    new_id = {8'(idx), salt1};
    delta  = c_el - last_deadline;
    if (delta > head.interval) begin
      delta = '0;
    end
    unique case (c_kind)
      KIND_SET: begin
        if (!found && !live) begin
          upd = '{id: new_id, is_interval: c_int, interval: c_dur, countdown: c_dur};
        end
      end
      KIND_CLEAR: begin
        if (match && head.is_interval == c_int) begin
          upd.id = '0;
        end
      end
      KIND_RESET: begin
        if (match && head.is_interval == c_int && !(c_int && c_dur == '0)) begin
          upd.interval  = c_dur;
          upd.countdown = c_dur;
        end
      end
      KIND_TICK: begin
        if (live) begin
          if (due) begin
            fire = 1'b1;
            if (head.is_interval) begin
              upd.countdown = head.interval - delta;
            end else begin
              upd.id = '0;
            end
          end else begin
            upd.countdown = head.countdown - c_el;
          end
        end
      end
      default: ;
    endcase
    shift = (state == S_RUN) && (!fire || out_free);
  end

  // output register loads a fire word or the final word
  assign out_load = (shift && fire) || (state == S_FINAL && out_free);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      salt          <= '0;
      last_deadline <= '0;
      out_valid     <= 1'b0;
      found         <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_kind <= kind;
            c_int  <= is_interval;
            c_tid  <= timer_id;
            c_dur  <= duration_ms;
            c_el   <= elapsed_ms;
            cnt    <= '0;
            found  <= 1'b0;
            res_id <= '0;
            mind   <= ALL_ONES;
            if (kind == KIND_SET && is_interval && duration_ms == '0) begin
              res_status <= ST_ZERO_INTERVAL;
              state      <= S_FINAL;
            end else begin
              res_status <= (kind == KIND_SET) ? ST_FULL :
                            (kind == KIND_TICK) ? ST_OK : ST_NO_TIMER;
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (shift) begin
            cnt <= cnt + CW'(1);
            if (cnt == CW'(SLOTS - 1)) begin
              state <= S_FINAL;
            end
            unique case (c_kind)
              KIND_SET: begin
                if (!found && !live) begin
                  found      <= 1'b1;
                  salt       <= salt1;
                  res_id     <= new_id;
                  res_status <= ST_OK;
                end
              end
              KIND_CLEAR, KIND_RESET: begin
                if (match) begin
                  if (head.is_interval != c_int) begin
                    res_status <= ST_WRONG_TYPE;
                  end else if (c_kind == KIND_RESET && c_int && c_dur == '0) begin
                    res_status <= ST_ZERO_INTERVAL;
                  end else begin
                    res_status <= ST_OK;
                    if (c_kind == KIND_RESET) begin
                      res_id <= head.id;
                    end
                  end
                end
              end
              KIND_TICK: begin
                if (upd.id != '0 && upd.countdown < mind) begin
                  mind <= upd.countdown;
                end
                if (fire) begin
                  status        <= ST_OK;
                  issued_id     <= '0;
                  fired         <= 1'b1;
                  fired_slot    <= 6'(idx);
                  next_deadline <= '0;
                  last          <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_FINAL: begin
          if (out_free) begin
            status        <= res_status;
            issued_id     <= res_id;
            fired         <= 1'b0;
            fired_slot    <= '0;
            last          <= 1'b1;
            next_deadline <= (c_kind == KIND_TICK) ? mind : '0;
            if (c_kind == KIND_TICK) begin
              last_deadline <= mind;
            end else if (res_status == ST_OK) begin
              last_deadline <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !shift) else $error("ring moved while idle");
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> !last && status == ST_OK)
    else $error("fire word marked last");
  a_issue_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && issued_id != '0 |-> status == ST_OK && last)
    else $error("id issued on failure");
  a_fire_hold: assert property (@(posedge clk) disable iff (rst)
    shift && fire |=> out_valid) else $error("fire word lost");
`endif
endmodule
`default_nettype wire
